>>> hdl/ppw_pkg.sv
// ----------------------------------------------------------------------------
// ppw_pkg
// shared types, widths and helpers of the point projection to window block
// ----------------------------------------------------------------------------
`default_nettype none

package ppw_pkg;

    // fixed point format of every value
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;

    // matrix arithmetic widths
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 4;
    localparam int CLIP_W = SUM_W - FRAC_BITS;
    localparam int MAG_W  = CLIP_W;

    // quotient is clamped to 2^Q_BITS, so Q_BITS quotient bits are resolved
    localparam int Q_BITS  = 46;
    localparam int DIV_LAT = Q_BITS + 2;

    // window mapping widths
    localparam int T_W  = Q_BITS + 3;
    localparam int VP_W = 16;
    localparam int P_W  = T_W + VP_W + 1;
    localparam int V_W  = P_W + 1;

    localparam logic signed [V_W-1:0] SAT_HI = V_W'(64'sd2147483647);
    localparam logic signed [V_W-1:0] SAT_LO = -SAT_HI - V_W'(1);

    // command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VP_XOFF   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VP_YOFF   = 2'd3;

    typedef struct packed {
        logic                     cmd;
        logic [3:0]               entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] point_z;
    } pt_item_t;

    typedef struct packed {
        logic                     valid_res;
        logic signed [DATA_W-1:0] window_x;
        logic signed [DATA_W-1:0] window_y;
        logic signed [DATA_W-1:0] window_depth;
    } win_item_t;

    // per-beat control that rides beside the arithmetic
    typedef struct packed {
        logic vld;
        logic wzero;
    } ctl_t;

    typedef struct packed {
        logic [VP_W-1:0] width;
        logic [VP_W-1:0] height;
        logic [VP_W-1:0] xoff;
        logic [VP_W-1:0] yoff;
    } vp_cfg_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [V_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[DATA_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ppw_clip.sv
// ----------------------------------------------------------------------------
// ppw_clip
// transform storage and clip vector pipeline: input, products, row sums, floor
// ----------------------------------------------------------------------------
`default_nettype none

module ppw_clip (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          pt_valid,
    input  wire ppw_pkg::pt_item_t             pt_data,
    output logic                               clip_vld,
    output logic signed [ppw_pkg::CLIP_W-1:0]  clip_x,
    output logic signed [ppw_pkg::CLIP_W-1:0]  clip_y,
    output logic signed [ppw_pkg::CLIP_W-1:0]  clip_z,
    output logic signed [ppw_pkg::CLIP_W-1:0]  clip_w
);
    import ppw_pkg::*;

    logic signed [DATA_W-1:0] mat_reg [16];

    logic     s0_vld_reg;
    pt_item_t s0_item_reg;

    logic                     prod_vld_reg, prod_vld_next;
    logic signed [PROD_W-1:0] prod_reg  [4][4];
    logic signed [PROD_W-1:0] prod_next [4][4];

    logic                    sum_vld_reg;
    logic signed [SUM_W-1:0] sum_reg  [4];
    logic signed [SUM_W-1:0] sum_next [4];

    logic                     clip_vld_reg;
    logic signed [CLIP_W-1:0] clip_reg [4];

    logic signed [DATA_W-1:0] pt [3];
    logic                     mat_we;

    assign pt[0] = s0_item_reg.point_x;
    assign pt[1] = s0_item_reg.point_y;
    assign pt[2] = s0_item_reg.point_z;

    assign mat_we        = en && s0_vld_reg && (s0_item_reg.cmd == CMD_LOAD);
    assign prod_vld_next = s0_vld_reg && (s0_item_reg.cmd == CMD_PROJECT);

    // matrix, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                mat_reg[i] <= ((i % 5) == 0) ? DATA_W'(1 << FRAC_BITS) : '0;
            end
        end
        else if (mat_we)
        begin
            mat_reg[s0_item_reg.entry_index] <= s0_item_reg.entry_value;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[r][k] = PROD_W'(mat_reg[r*4+k]) * PROD_W'(pt[k]);
            end
            // w term of the point is one
            prod_next[r][3] = PROD_W'(mat_reg[r*4+3]) <<< FRAC_BITS;
            sum_next[r] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                        + SUM_W'(prod_reg[r][2]) + SUM_W'(prod_reg[r][3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
            clip_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg   <= pt_valid;
            prod_vld_reg <= prod_vld_next;
            sum_vld_reg  <= prod_vld_reg;
            clip_vld_reg <= sum_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_item_reg <= pt_data;
            prod_reg    <= prod_next;
            sum_reg     <= sum_next;
            for (int r = 0; r < 4; r++)
            begin
                clip_reg[r] <= CLIP_W'(sum_reg[r] >>> FRAC_BITS);
            end
        end
    end

    assign clip_vld = clip_vld_reg;
    assign clip_x   = clip_reg[0];
    assign clip_y   = clip_reg[1];
    assign clip_z   = clip_reg[2];
    assign clip_w   = clip_reg[3];

endmodule

`default_nettype wire

>>> hdl/ppw_div.sv
// ----------------------------------------------------------------------------
// ppw_div
// pipelined restoring divider, one quotient bit per stage, clamped magnitude
// ----------------------------------------------------------------------------
`default_nettype none

module ppw_div (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [ppw_pkg::CLIP_W-1:0] num,
    input  wire logic signed [ppw_pkg::CLIP_W-1:0] den,
    output logic [ppw_pkg::Q_BITS:0]           mag,
    output logic                               neg
);
    import ppw_pkg::*;

    localparam int SH  = Q_BITS - FRAC_BITS;
    localparam int R_W = MAG_W + 1;

    // sign and magnitude stage
    logic [MAG_W-1:0] a_reg;
    logic [MAG_W-1:0] b0_reg;
    logic             neg0_reg;

    // division stages, entry 0 is the set-up stage
    logic [MAG_W-1:0]  r_reg   [Q_BITS+1];
    logic [MAG_W-1:0]  b_reg   [Q_BITS+1];
    logic [Q_BITS-1:0] n_reg   [Q_BITS+1];
    logic [Q_BITS-1:0] q_reg   [Q_BITS+1];
    logic              neg_reg [Q_BITS+1];
    logic              sat_reg [Q_BITS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= num[CLIP_W-1] ? MAG_W'(-num) : MAG_W'(num);
            b0_reg   <= den[CLIP_W-1] ? MAG_W'(-den) : MAG_W'(den);
            neg0_reg <= num[CLIP_W-1] ^ den[CLIP_W-1];
            // integer part at or past the limit clamps the magnitude
            sat_reg[0] <= (a_reg >> SH) >= b0_reg;
            r_reg[0]   <= a_reg >> SH;
            b_reg[0]   <= b0_reg;
            n_reg[0]   <= Q_BITS'({a_reg, FRAC_BITS'(0)});
            q_reg[0]   <= '0;
            neg_reg[0] <= neg0_reg;
        end
    end

    for (genvar j = 0; j < Q_BITS; j++)
    begin : g_step
        logic [R_W-1:0] rs;
        logic           bit_q;

        assign rs    = {r_reg[j], n_reg[j][Q_BITS-1]};
        assign bit_q = rs >= {1'b0, b_reg[j]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j+1]   <= bit_q ? MAG_W'(rs - {1'b0, b_reg[j]}) : MAG_W'(rs);
                b_reg[j+1]   <= b_reg[j];
                n_reg[j+1]   <= {n_reg[j][Q_BITS-2:0], 1'b0};
                q_reg[j+1]   <= {q_reg[j][Q_BITS-2:0], bit_q};
                neg_reg[j+1] <= neg_reg[j];
                sat_reg[j+1] <= sat_reg[j];
            end
        end
    end

    assign mag = sat_reg[Q_BITS] ? {1'b1, Q_BITS'(0)} : {1'b0, q_reg[Q_BITS]};
    assign neg = neg_reg[Q_BITS];

endmodule

`default_nettype wire

>>> hdl/ppw_map.sv
// ----------------------------------------------------------------------------
// ppw_map
// viewport mapping: sign and bias, viewport scale, offset and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module ppw_map (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire ppw_pkg::ctl_t             ctl_in,
    input  wire ppw_pkg::vp_cfg_t          vp,
    input  wire logic [ppw_pkg::Q_BITS:0]  mag_x,
    input  wire logic [ppw_pkg::Q_BITS:0]  mag_y,
    input  wire logic [ppw_pkg::Q_BITS:0]  mag_z,
    input  wire logic                      neg_x,
    input  wire logic                      neg_y,
    input  wire logic                      neg_z,
    output logic                           res_vld,
    output ppw_pkg::win_item_t             res
);
    import ppw_pkg::*;

    ctl_t ctl1_reg, ctl2_reg, ctl3_reg;

    logic signed [T_W-1:0] tx_reg, ty_reg, tz_reg;
    logic signed [P_W-1:0] px_reg, py_reg;
    logic signed [T_W-1:0] tz2_reg;
    win_item_t             res_reg, res_next;

    function automatic logic signed [T_W-1:0] bias(input logic [Q_BITS:0] m, input logic n);
        logic signed [T_W-1:0] q;
        q = T_W'($signed({1'b0, m}));
        return (n ? -q : q) + T_W'(1 << FRAC_BITS);
    endfunction

    always_comb
    begin
        res_next.valid_res = !ctl2_reg.wzero;
        res_next.window_x  = sat32(V_W'(px_reg >>> 1)
                           + V_W'($signed({1'b0, vp.xoff, FRAC_BITS'(0)})));
        res_next.window_y  = sat32(V_W'(py_reg >>> 1)
                           + V_W'($signed({1'b0, vp.yoff, FRAC_BITS'(0)})));
        res_next.window_depth = sat32(V_W'(tz2_reg >>> 1));
        // zero clip w gives an all-zero beat
        if (ctl2_reg.wzero)
        begin
            res_next.window_x     = '0;
            res_next.window_y     = '0;
            res_next.window_depth = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg  <= bias(mag_x, neg_x);
            ty_reg  <= bias(mag_y, neg_y);
            tz_reg  <= bias(mag_z, neg_z);
            px_reg  <= P_W'(tx_reg) * P_W'($signed({1'b0, vp.width}));
            py_reg  <= P_W'(ty_reg) * P_W'($signed({1'b0, vp.height}));
            tz2_reg <= tz_reg;
            res_reg <= res_next;
        end
    end

    assign res_vld = ctl3_reg.vld;
    assign res     = res_reg;

endmodule

`default_nettype wire

>>> hdl/point_projection_to_window.sv
// ----------------------------------------------------------------------------
// point_projection_to_window
// projects points through a stored 4x4 transform to viewport window coordinates
// ----------------------------------------------------------------------------
// The block takes one beat per clock while pt_stall is low. A load beat
// (cmd 0) writes one entry of the combined projection-view matrix and gives
// no result; a project beat (cmd 1) gives exactly one result beat, in order.
// A project beat passes 4 + 48 + 3 = 55 register stages: input, products, row
// sums and clip floor, then the divider's sign stage, set-up stage and 46
// quotient-bit stages, then bias, viewport scale and the result register,
// before its result beat shows on win_valid. The divider resolves one
// quotient bit per stage for each of x, y and z. The whole pipeline advances
// together and pt_stall rises only while a result beat is held by win_stall.
// All values are signed Q16.16 and results saturate. When clip w is zero the
// result has valid_res low and zero coordinates. The matrix resets to
// identity, the viewport to 640 x 480 at offset 0. The user must see that
// viewport registers are written only while the block is empty; the block
// itself does not enforce this, and the live values are used by beats in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module point_projection_to_window (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // point / load channel
    input  wire logic                             pt_valid,
    output logic                                  pt_stall,
    input  wire ppw_pkg::pt_item_t                pt_data,
    // window result channel
    output logic                                  win_valid,
    input  wire logic                             win_stall,
    output ppw_pkg::win_item_t                    win_data,
    // viewport register writes
    input  wire logic                             cfg_we,
    input  wire logic [ppw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ppw_pkg::VP_W-1:0]         cfg_data
);
    import ppw_pkg::*;

    // global advance: only a blocked result beat holds the pipe
    logic en;

    vp_cfg_t vp_reg;

    logic                     clip_vld;
    logic signed [CLIP_W-1:0] clip_x, clip_y, clip_z, clip_w;

    // control rides beside the divider stages
    ctl_t ctl_pipe_reg [DIV_LAT];
    ctl_t ctl_in;

    logic [Q_BITS:0] mag_x, mag_y, mag_z;
    logic            neg_x, neg_y, neg_z;

    assign en       = !(win_valid && win_stall);
    assign pt_stall = !en;

    // viewport registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg.width  <= VP_W'(640);
            vp_reg.height <= VP_W'(480);
            vp_reg.xoff   <= '0;
            vp_reg.yoff   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VP_WIDTH:  vp_reg.width  <= cfg_data;
                REG_VP_HEIGHT: vp_reg.height <= cfg_data;
                REG_VP_XOFF:   vp_reg.xoff   <= cfg_data;
                REG_VP_YOFF:   vp_reg.yoff   <= cfg_data;
                default:       vp_reg        <= vp_reg;
            endcase
        end
    end

    // input register, products, row sums, floor to clip vector
    ppw_clip u_clip (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .pt_valid (pt_valid),
        .pt_data  (pt_data),
        .clip_vld (clip_vld),
        .clip_x   (clip_x),
        .clip_y   (clip_y),
        .clip_z   (clip_z),
        .clip_w   (clip_w)
    );

    assign ctl_in.vld   = clip_vld;
    assign ctl_in.wzero = (clip_w == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                ctl_pipe_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            ctl_pipe_reg[0] <= ctl_in;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                ctl_pipe_reg[i] <= ctl_pipe_reg[i-1];
            end
        end
    end

    // perspective divide, one divider per coordinate
    ppw_div u_div_x (
        .clk (clk), .en (en), .num (clip_x), .den (clip_w), .mag (mag_x), .neg (neg_x)
    );

    ppw_div u_div_y (
        .clk (clk), .en (en), .num (clip_y), .den (clip_w), .mag (mag_y), .neg (neg_y)
    );

    ppw_div u_div_z (
        .clk (clk), .en (en), .num (clip_z), .den (clip_w), .mag (mag_z), .neg (neg_z)
    );

    // viewport mapping and result register
    ppw_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_pipe_reg[DIV_LAT-1]),
        .vp      (vp_reg),
        .mag_x   (mag_x),
        .mag_y   (mag_y),
        .mag_z   (mag_z),
        .neg_x   (neg_x),
        .neg_y   (neg_y),
        .neg_z   (neg_z),
        .res_vld (win_valid),
        .res     (win_data)
    );

endmodule

`default_nettype wire

>>> hdl/ppw_checker.sv
// ----------------------------------------------------------------------------
// ppw_checker
// port-level checks of the projection block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ppw_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          pt_stall,
    input wire logic                          win_valid,
    input wire logic                          win_stall,
    input wire ppw_pkg::win_item_t            win_data
);
    import ppw_pkg::*;

    // a blocked result beat holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid && win_stall) |=> (win_valid && $stable(win_data)))
        else $error("result beat changed while stalled");

    // input is held back only by a blocked result beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pt_stall |-> (win_valid && win_stall))
        else $error("input stalled without a blocked result");

    // a beat without a projection carries zero coordinates
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid && !win_data.valid_res) |->
        (win_data.window_x == '0 && win_data.window_y == '0 &&
         win_data.window_depth == '0))
        else $error("invalid projection with nonzero coordinates");

    // no result beat appears right after reset release
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !win_valid)
        else $error("result beat right after reset");

endmodule

bind point_projection_to_window ppw_checker u_ppw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt_stall  (pt_stall),
    .win_valid (win_valid),
    .win_stall (win_stall),
    .win_data  (win_data)
);

`default_nettype wire
